/* sv/assert_macros.svh */
// Assertion macros shared by the tokenizer RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define CLT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/clt_pkg.sv */
// Types and constants for the command line tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package clt_pkg;

  localparam int unsigned MAX_RES = 4;

  // Lexer phase, one-hot.
  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_NUMBER = 5'b00010,
    PH_IDKW   = 5'b00100,
    PH_IDENT  = 5'b01000,
    PH_OPER   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    TT_NUMBER   = 3'd0,
    TT_IDENT    = 3'd1,
    TT_KEYWORD  = 3'd2,
    TT_OPERATOR = 3'd3,
    TT_SEP      = 3'd4,
    TT_STRING   = 3'd5,
    TT_DISCARD  = 3'd6
  } tok_type_t;

  typedef struct packed {
    phase_t      phase;
    logic        dot_seen;
    logic        stray_prefix;
    logic [7:0]  keyword_hits;
    logic [3:0]  word_length;
    logic        operator_first;  // first char may take a trailing '='
    logic        in_string;
    logic        quote_double;
    logic        pending_quote;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    phase:          PH_START,
    dot_seen:       1'b0,
    stray_prefix:   1'b0,
    keyword_hits:   8'h00,
    word_length:    4'd0,
    operator_first: 1'b0,
    in_string:      1'b0,
    quote_double:   1'b0,
    pending_quote:  1'b0
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] body_char;
    tok_type_t  token_type;
  } res_t;

  // All results caused by one input word.
  typedef struct packed {
    logic [2:0]              count;
    res_t [MAX_RES-1:0]      res;
  } bundle_t;

endpackage

/* sv/clt_in_if.sv */
// Input channel of the tokenizer: one command byte per word.
// No dependencies.
`timescale 1ns / 1ps

interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_command;

  modport source (output valid, output ch, output end_of_command, input ready);
  modport sink   (input valid, input ch, input end_of_command, output ready);
endinterface

/* sv/clt_out_if.sv */
// Result channel of the tokenizer: one body, close or end result per word.
// No dependencies.
`timescale 1ns / 1ps

interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] body_char;
  logic [2:0] token_type;
  logic       run_end;

  modport source (output valid, output kind, output body_char, output token_type,
                  output run_end, input ready);
  modport sink   (input valid, input kind, input body_char, input token_type,
                  input run_end, output ready);
endinterface

/* sv/clt_lexer.sv */
// Next-state and result logic of the tokenizer for one command byte.
// Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_lexer (
  input  clt_pkg::lex_state_t st,
  input  logic [7:0]          ch,
  input  logic                end_of_command,
  output clt_pkg::lex_state_t st_nxt,
  output clt_pkg::bundle_t    bundle
);

  // Keyword spellings, right justified, and their lengths.
  localparam logic [79:0] KW_TEXT [8] = '{
    "unset", "set", "write", "ip", "port", "load", "terminator", "assert"
  };
  localparam logic [3:0] KW_LEN [8] = '{
    4'd5, 4'd3, 4'd5, 4'd2, 4'd4, 4'd4, 4'd10, 4'd6
  };
  localparam int unsigned NCAND = 7;

  function automatic logic [7:0] kw_filter(input logic [7:0] mask, input logic [3:0] pos,
                                           input logic [7:0] c);
    logic [7:0] keep;
    logic [7:0] lc;
    logic [6:0] bpos;
    keep = '0;
    lc   = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    for (int i = 0; i < 8; i++) begin
      bpos = {KW_LEN[i] - 4'd1 - pos, 3'b000};
      if (mask[i] && (pos < KW_LEN[i])) begin
        if (KW_TEXT[i][bpos +: 8] == lc) keep[i] = 1'b1;
      end
    end
    return keep;
  endfunction

  function automatic clt_pkg::tok_type_t phase_type(input clt_pkg::lex_state_t s);
    logic hit;
    clt_pkg::tok_type_t t;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (s.keyword_hits[i] && (KW_LEN[i] == s.word_length)) hit = 1'b1;
    end
    unique case (s.phase)
      clt_pkg::PH_NUMBER: t = clt_pkg::TT_NUMBER;
      clt_pkg::PH_IDKW:   t = (!s.stray_prefix && hit) ? clt_pkg::TT_KEYWORD : clt_pkg::TT_IDENT;
      clt_pkg::PH_OPER:   t = clt_pkg::TT_OPERATOR;
      default:            t = clt_pkg::TT_IDENT;
    endcase
    return t;
  endfunction

  function automatic clt_pkg::lex_state_t clear_token(input clt_pkg::lex_state_t s);
    clt_pkg::lex_state_t r;
    r                = s;
    r.phase          = clt_pkg::PH_START;
    r.dot_seen       = 1'b0;
    r.stray_prefix   = 1'b0;
    r.keyword_hits   = 8'h00;
    r.word_length    = 4'd0;
    r.operator_first = 1'b0;
    return r;
  endfunction

  function automatic clt_pkg::res_t mk_close(input clt_pkg::tok_type_t t);
    clt_pkg::res_t r;
    r.kind       = clt_pkg::KIND_CLOSE;
    r.body_char  = 8'h00;
    r.token_type = t;
    return r;
  endfunction

  // Candidate slots in emission order:
  // 0 close of previous token, 1 body, 2 separator/string close,
  // 3 close at end, 4 lone quote body, 5 string/sep/discard close, 6 end marker.
  logic [NCAND-1:0] cv;
  clt_pkg::res_t    cand [NCAND];

  logic is_dig, is_let, is_spc, is_op, is_sep, is_quote, is_dq;

  assign is_dig   = (ch >= "0") && (ch <= "9");
  assign is_let   = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
  assign is_spc   = (ch == " ") || (ch == 8'h09) || (ch == 8'h0A);
  assign is_op    = (ch == "=") || (ch == "+") || (ch == "-") || (ch == "*") ||
                    (ch == "/") || (ch == "%") || (ch == "!") || (ch == "<") || (ch == ">");
  assign is_sep   = (ch == ",") || (ch == ";") || (ch == ".") || (ch == "'") ||
                    (ch == "\"") || (ch == "(") || (ch == ")") || (ch == "{") || (ch == "}");
  assign is_dq    = (ch == "\"");
  assign is_quote = is_dq || (ch == "'");

  always_comb begin
    clt_pkg::lex_state_t s;
    clt_pkg::res_t       body;
    logic                cont;
    logic                start;
    s     = st;
    cont  = 1'b0;
    start = 1'b0;
    cv    = '0;
    for (int j = 0; j < NCAND; j++) cand[j] = '0;
    body.kind       = clt_pkg::KIND_BODY;
    body.body_char  = ch;
    body.token_type = clt_pkg::TT_NUMBER;

    // continue the open token if the byte extends it
    unique case (s.phase)
      clt_pkg::PH_NUMBER: begin
        if (is_dig || (ch == "." && !s.dot_seen)) begin
          cont = 1'b1;
          if (ch == ".") s.dot_seen = 1'b1;
        end
      end
      clt_pkg::PH_IDKW: begin
        if (is_dig) begin
          cont    = 1'b1;
          s.phase = clt_pkg::PH_IDENT;
        end else if (is_let || ch == "_") begin
          cont           = 1'b1;
          s.keyword_hits = kw_filter(s.keyword_hits, s.word_length, ch);
          if (s.word_length != 4'hF) s.word_length = s.word_length + 4'd1;
        end
      end
      clt_pkg::PH_IDENT: cont = is_dig || is_let || (ch == "_");
      clt_pkg::PH_OPER: begin
        if (s.operator_first && ch == "=") begin
          cont             = 1'b1;
          s.operator_first = 1'b0;
        end
      end
      default: start = 1'b1;
    endcase

    if (cont) begin
      cv[1]           = 1'b1;
      cand[1]         = body;
      s.pending_quote = 1'b0;
    end else begin
      if (!start) begin
        cv[0]   = !s.in_string;
        cand[0] = mk_close(phase_type(s));
        s       = clear_token(s);
      end
      // start of a new token
      if (is_spc) begin
        // dropped
      end else if (is_dig) begin
        cv[1] = 1'b1; cand[1] = body; s.pending_quote = 1'b0;
        s.phase = clt_pkg::PH_NUMBER;
      end else if (is_let) begin
        cv[1] = 1'b1; cand[1] = body; s.pending_quote = 1'b0;
        s.phase        = clt_pkg::PH_IDKW;
        s.keyword_hits = kw_filter(8'hFF, 4'd0, ch);
        s.word_length  = 4'd1;
      end else if (is_op) begin
        cv[1] = 1'b1; cand[1] = body; s.pending_quote = 1'b0;
        s.phase          = clt_pkg::PH_OPER;
        s.operator_first = !s.stray_prefix && ((ch == "<") || (ch == ">") || (ch == "!"));
      end else if (is_sep) begin
        if (is_quote && !s.stray_prefix && !s.in_string) begin
          // bare quote opens a string
          s.in_string     = 1'b1;
          s.quote_double  = is_dq;
          s.pending_quote = 1'b1;
        end else if (is_quote && !s.stray_prefix && (is_dq == s.quote_double)) begin
          // matching bare quote closes the string
          cv[2]           = 1'b1;
          cand[2]         = mk_close(clt_pkg::TT_STRING);
          s.in_string     = 1'b0;
          s.quote_double  = 1'b0;
          s.pending_quote = 1'b0;
        end else begin
          cv[1] = 1'b1; cand[1] = body; s.pending_quote = 1'b0;
          cv[2]   = !s.in_string;
          cand[2] = mk_close(clt_pkg::TT_SEP);
          s       = clear_token(s);
        end
      end else begin
        // stray character, prefixes the next token
        cv[1] = 1'b1; cand[1] = body; s.pending_quote = 1'b0;
        s.stray_prefix = 1'b1;
      end
    end

    if (end_of_command) begin
      if (s.phase != clt_pkg::PH_START) begin
        cv[3]   = !s.in_string;
        cand[3] = mk_close(phase_type(s));
        s       = clear_token(s);
      end
      if (s.in_string) begin
        if (s.pending_quote) begin
          // nothing but whitespace after the quote: it was a separator
          cv[4]             = 1'b1;
          cand[4].kind      = clt_pkg::KIND_BODY;
          cand[4].body_char = s.quote_double ? 8'h22 : 8'h27;
          cv[5]             = 1'b1;
          cand[5]           = mk_close(clt_pkg::TT_SEP);
        end else begin
          cv[5]   = 1'b1;
          cand[5] = mk_close(clt_pkg::TT_STRING);
        end
      end else if (s.stray_prefix) begin
        cv[5]   = 1'b1;
        cand[5] = mk_close(clt_pkg::TT_DISCARD);
      end
      cv[6]        = 1'b1;
      cand[6].kind = clt_pkg::KIND_END;
      s            = clt_pkg::LEX_RESET;
    end

    st_nxt = s;
  end

  // pack the valid candidates into the first slots, keeping at most MAX_RES
  always_comb begin
    logic [2:0] n;
    n          = 3'd0;
    bundle.res = '0;
    for (int j = 0; j < NCAND; j++) begin
      if (cv[j]) begin
        if (n < 3'(clt_pkg::MAX_RES)) bundle.res[n[1:0]] = cand[j];
        n = n + 3'd1;
      end
    end
    bundle.count = (n > 3'(clt_pkg::MAX_RES)) ? 3'(clt_pkg::MAX_RES) : n;
  end

endmodule

/* sv/clt_result_buf.sv */
// Result register of the tokenizer: holds one word's results and sends them in order.
// Depends on clt_pkg, clt_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clt_result_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  clt_pkg::bundle_t      bundle,
  output logic                  free,
  clt_out_if.source             out_chan
);

  clt_pkg::bundle_t bun_r;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             drain, last;
  clt_pkg::res_t    cur;

  assign drain = out_chan.valid && out_chan.ready;
  assign last  = ({1'b0, idx_r} == (cnt_r - 3'd1));
  assign free  = (cnt_r == 3'd0) || (drain && last);
  assign cur   = bun_r.res[idx_r];

  assign out_chan.valid      = (cnt_r != 3'd0);
  assign out_chan.kind       = cur.kind;
  assign out_chan.body_char  = cur.body_char;
  assign out_chan.token_type = cur.token_type;
  assign out_chan.run_end    = last;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (drain) begin
      if (last) begin
        cnt_nxt = 3'd0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (load) begin
      cnt_nxt = bundle.count;
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) bun_r <= bundle;
  end

  `CLT_ASSERT(a_cnt_range, cnt_r <= 3'(clt_pkg::MAX_RES), "result count out of range")
  `CLT_ASSERT_IMP(a_idx_range, cnt_r != 3'd0, {1'b0, idx_r} < cnt_r, "read index past count")
  `CLT_ASSERT_IMP(a_no_overwrite, load, (cnt_r == 3'd0) || (drain && last),
                  "results overwritten before sent")

endmodule

/* sv/command_line_tokenizer_top.sv */
// Command line tokenizer, top level. Depends on clt_pkg, clt_in_if, clt_out_if,
// clt_lexer, clt_result_buf and assert_macros.svh.
// Latency: first result of a word is valid the cycle after the word is taken.
// Throughput: one word per cycle if each has one result and the output is ready;
// a word with n results (n up to 4) holds the input while they are sent in turn.
// Reset: synchronous, active low rst_n; clears lexer state and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module command_line_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  clt_in_if.sink     in_chan,
  clt_out_if.source  out_chan
);

  // Lexer state: token phase, keyword matcher, string tracking.
  clt_pkg::lex_state_t st_r, st_nxt;
  clt_pkg::bundle_t    bundle;
  logic                in_acc;
  logic                buf_free;

  // A word is taken whenever the result register is empty or sends its
  // last result in this cycle; a word that leaves no results, such as
  // whitespace after whitespace, does not load the result register.
  assign in_chan.ready = buf_free;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Combinational classification, keyword compare and result packing.
  clt_lexer u_lexer (
    .st             (st_r),
    .ch             (in_chan.ch),
    .end_of_command (in_chan.end_of_command),
    .st_nxt         (st_nxt),
    .bundle         (bundle)
  );

  // Output register plus per-word result sequencer.
  clt_result_buf u_result_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_acc && (bundle.count != 3'd0)),
    .bundle   (bundle),
    .free     (buf_free),
    .out_chan (out_chan)
  );

  // State advances only on a taken word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= clt_pkg::LEX_RESET;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // End of command always returns the lexer to its idle state.
  `CLT_ASSERT_NXT(a_eoc_resets, in_acc && in_chan.end_of_command,
                  (st_r.phase == clt_pkg::PH_START) && !st_r.in_string,
                  "lexer not idle after end of command")
  // Nothing pending on the output means the input must be open.
  `CLT_ASSERT_IMP(a_ready_when_empty, !out_chan.valid, in_chan.ready,
                  "input stalled with empty result register")

endmodule
